// ===== sv/fir_correlation_filter_unit_assert.svh =====
// assertion macros for the fir correlation filter unit
`ifndef FIR_CORRELATION_FILTER_UNIT_ASSERT_SVH
`define FIR_CORRELATION_FILTER_UNIT_ASSERT_SVH

`ifndef SYNTH
// consequent must hold in the same cycle as the antecedent
`define FCF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fcf assertion failed");
// consequent must hold in the cycle after the antecedent
`define FCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fcf assertion failed");
`else
`define FCF_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define FCF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/fcf_pkg.sv =====
// shared constants and controller/datapath types for the fir correlation filter
package fcf_pkg;

	// default sizing
	localparam int MAX_TAPS_DEF    = 64;
	localparam int SAMPLE_BITS_DEF = 16;

	// fixed field widths
	localparam int TAP_COUNT_W    = 7;
	localparam int WEIGHT_INDEX_W = 6;
	localparam int RESULT_W       = 38;

	localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 7'd1;

	// request type codes
	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	// commands from controller to datapath
	typedef struct packed {
		logic load_weight;
		logic take_sample;
		logic step;
		logic load_out;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic win_full;
		logic last_tap;
		logic pipe_busy;
		logic out_busy;
	} status_t;

endpackage

// ===== sv/fcf_intf.sv =====
// request and result channel interfaces
interface fcf_req_if #(
	parameter int SAMPLE_BITS = fcf_pkg::SAMPLE_BITS_DEF
);
	logic                                     valid;
	logic                                     ready;
	logic                                     req_type;
	logic [fcf_pkg::WEIGHT_INDEX_W-1:0]       weight_index;
	logic signed [SAMPLE_BITS-1:0]            data_value;
	logic                                     end_of_block;

	modport source (
		output valid, req_type, weight_index, data_value, end_of_block,
		input  ready
	);
	modport sink (
		input  valid, req_type, weight_index, data_value, end_of_block,
		output ready
	);
endinterface

interface fcf_res_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [fcf_pkg::RESULT_W-1:0]   filtered_value;
	logic                                  last_of_block;

	modport source (
		output valid, filtered_value, last_of_block,
		input  ready
	);
	modport sink (
		input  valid, filtered_value, last_of_block,
		output ready
	);
endinterface

// ===== sv/fcf_ctrl.sv =====
// controller state machine sequencing loads, samples and the tap loop
module fcf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_sample,
	input  fcf_pkg::status_t status,
	output logic             in_ready,
	output fcf_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_FLUSH = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nx;

	// next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready         = 1'b1;
				cmd.load_weight  = in_valid && !in_sample;
				cmd.take_sample  = in_valid && in_sample;
				if (in_valid && in_sample && status.win_full) begin
					state_nx = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.step = 1'b1;
				if (status.last_tap) begin
					state_nx = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!status.pipe_busy) begin
					state_nx = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!status.out_busy) begin
					cmd.load_out = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

// ===== sv/fcf_datapath.sv =====
// stores, pointers, multiply-accumulate pipeline and result register
module fcf_datapath #(
	parameter int MAX_TAPS    = fcf_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = fcf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [fcf_pkg::TAP_COUNT_W-1:0]        cfg_wdata,
	input  fcf_pkg::cmd_t                          cmd,
	input  logic [fcf_pkg::WEIGHT_INDEX_W-1:0]     weight_index,
	input  logic signed [SAMPLE_BITS-1:0]          data_value,
	input  logic                                   end_of_block,
	input  logic                                   out_ready,
	output fcf_pkg::status_t                       status,
	output logic                                   out_valid,
	output logic signed [fcf_pkg::RESULT_W-1:0]    out_value,
	output logic                                   out_last
);

	localparam int PW = $clog2(MAX_TAPS);
	localparam int CW = $clog2(MAX_TAPS + 1);
	localparam int RW = fcf_pkg::RESULT_W;
	localparam int MW = 2 * SAMPLE_BITS;

	logic [fcf_pkg::TAP_COUNT_W-1:0] tap_count_q;
	logic [31:0]                     taps32;
	logic [CW-1:0]                   taps;
	logic [CW-1:0]                   fill_q;
	logic [CW-1:0]                   fill_nx;
	logic [CW-1:0]                   tap_q;
	logic [PW-1:0]                   wr_ptr_q;
	logic [PW-1:0]                   wr_ptr_nx;
	logic [PW-1:0]                   rd_ptr_q;
	logic [PW-1:0]                   rd_ptr_nx;
	logic [31:0]                     start32;
	logic [31:0]                     idx32;
	logic                            eob_q;

	logic signed [SAMPLE_BITS-1:0]   w_mem [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0]   h_mem [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0]   w_rd_s1;
	logic signed [SAMPLE_BITS-1:0]   h_rd_s1;
	logic                            rd_valid_s1;
	logic signed [MW-1:0]            prod_s2;
	logic                            mul_valid_s2;
	logic signed [RW-1:0]            acc_q;
	logic                            out_valid_q;
	logic signed [RW-1:0]            out_value_q;
	logic                            out_last_q;

	// tap count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= fcf_pkg::TAP_COUNT_RESET;
		end else if (cfg_we) begin
			tap_count_q <= cfg_wdata;
		end
	end

	// taps in use: zero reads as one, large values clamp to the store depth
	always_comb begin
		if (tap_count_q == '0) begin
			taps32 = 32'd1;
		end else if (32'(tap_count_q) > 32'(MAX_TAPS)) begin
			taps32 = 32'(MAX_TAPS);
		end else begin
			taps32 = 32'(tap_count_q);
		end
	end
	assign taps = taps32[CW-1:0];

	// window fill and pointer arithmetic
	assign fill_nx   = (fill_q == CW'(MAX_TAPS)) ? fill_q : fill_q + CW'(1);
	assign wr_ptr_nx = (wr_ptr_q == PW'(MAX_TAPS - 1)) ? '0 : wr_ptr_q + PW'(1);
	assign rd_ptr_nx = (rd_ptr_q == PW'(MAX_TAPS - 1)) ? '0 : rd_ptr_q + PW'(1);

	// oldest window slot sits taps positions behind the next write slot
	always_comb begin
		if (32'(wr_ptr_nx) >= taps32) begin
			start32 = 32'(wr_ptr_nx) - taps32;
		end else begin
			start32 = 32'(wr_ptr_nx) + 32'(MAX_TAPS) - taps32;
		end
	end

	assign idx32 = 32'(weight_index);

	// coefficient store
	always_ff @(posedge clk) begin
		if (cmd.load_weight && (idx32 < 32'(MAX_TAPS))) begin
			w_mem[idx32[PW-1:0]] <= data_value;
		end
		if (cmd.step) begin
			w_rd_s1 <= w_mem[tap_q[PW-1:0]];
		end
	end

	// sample history store
	always_ff @(posedge clk) begin
		if (cmd.take_sample) begin
			h_mem[wr_ptr_q] <= data_value;
		end
		if (cmd.step) begin
			h_rd_s1 <= h_mem[rd_ptr_q];
		end
	end

	// fill count, pointers and tap counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			tap_q    <= '0;
		end else if (cmd.take_sample) begin
			fill_q   <= fill_nx;
			wr_ptr_q <= wr_ptr_nx;
			rd_ptr_q <= start32[PW-1:0];
			tap_q    <= '0;
		end else if (cmd.step) begin
			rd_ptr_q <= rd_ptr_nx;
			tap_q    <= tap_q + CW'(1);
		end
	end

	// end-of-block flag of the sample in flight
	always_ff @(posedge clk) begin
		if (cmd.take_sample) begin
			eob_q <= end_of_block;
		end
	end

	// pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1  <= 1'b0;
			mul_valid_s2 <= 1'b0;
		end else begin
			rd_valid_s1  <= cmd.step;
			mul_valid_s2 <= rd_valid_s1;
		end
	end

	// multiply stage
	always_ff @(posedge clk) begin
		if (rd_valid_s1) begin
			prod_s2 <= h_rd_s1 * w_rd_s1;
		end
	end

	// accumulate, wrapping in the result width
	always_ff @(posedge clk) begin
		if (cmd.take_sample) begin
			acc_q <= '0;
		end else if (mul_valid_s2) begin
			acc_q <= acc_q + RW'(prod_s2);
		end
	end

	// result register, held until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_value_q <= acc_q;
			out_last_q  <= eob_q;
		end
	end

	// status to controller
	assign status.win_full  = 32'(fill_nx) >= taps32;
	assign status.last_tap  = tap_q == (taps - CW'(1));
	assign status.pipe_busy = rd_valid_s1 || mul_valid_s2;
	assign status.out_busy  = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;

endmodule

// ===== sv/fir_correlation_filter_unit.sv =====
// top level of the streaming fir correlation filter
//
// usage:
//  req channel: valid/ready transfer of one item. req_type low writes
//  data_value into coefficient slot weight_index (slots past the store
//  depth are dropped); req_type high pushes data_value into the sample
//  history. res channel: one filtered_value per sample once tap_count
//  samples are held, with last_of_block copied from the sample.
//  cfg_we/cfg_wdata write tap_count; write it only while the block is idle.
//  a sample that completes the window starts a tap loop over taps (tap_count
//  held to 1..MAX_TAPS), run by the single shared multiply-accumulate that
//  visits one tap per cycle through one read port of each store; input
//  waits until its result is loaded. coefficient loads and samples that do
//  not complete the window leave the block idle, ready for the next item.
//  reset: tap_count returns to 1 and the history counts as empty; the
//  coefficient store holds no defined value until written.
//  a stalled receiver holds the result register; the next item is still
//  taken, but once its tap loop ends its result waits until the slot frees.
module fir_correlation_filter_unit #(
	parameter int MAX_TAPS    = fcf_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = fcf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [fcf_pkg::TAP_COUNT_W-1:0]   cfg_wdata,
	fcf_req_if.sink                           req,
	fcf_res_if.source                         res
);

	`include "fir_correlation_filter_unit_assert.svh"

	fcf_pkg::cmd_t    cmd;
	fcf_pkg::status_t status;
	logic             in_sample;

	assign in_sample = req.req_type == fcf_pkg::REQ_SAMPLE;

	// controller
	fcf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_sample (in_sample),
		.status    (status),
		.in_ready  (req.ready),
		.cmd       (cmd)
	);

	// datapath
	fcf_datapath #(
		.MAX_TAPS    (MAX_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.weight_index (req.weight_index),
		.data_value   (req.data_value),
		.end_of_block (req.end_of_block),
		.out_ready    (res.ready),
		.status       (status),
		.out_valid    (res.valid),
		.out_value    (res.filtered_value),
		.out_last     (res.last_of_block)
	);

	// a new result never overwrites one still waiting for its transfer
	`FCF_ASSERT_SAME(a_no_overwrite, clk, arst_n, cmd.load_out, !(res.valid && !res.ready))
	// a sample that completes the window starts the tap loop and blocks input
	`FCF_ASSERT_NEXT(a_run_blocks, clk, arst_n, req.valid && req.ready && in_sample && status.win_full, !req.ready)
	// the multiply pipeline is empty whenever input is taken
	`FCF_ASSERT_SAME(a_pipe_idle, clk, arst_n, req.ready, !status.pipe_busy)

endmodule
